// File: hw/rtl/zsbf_pkg.sv
package zsbf_pkg;

  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

  localparam logic [7:0]  ZLIB_CMF        = 8'h78;
  localparam logic [7:0]  ZLIB_FLG        = 8'h01;
  localparam logic [15:0] MAX_BLOCK       = 16'd65535;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [31:0] TOTAL_LEN_RESET = 32'd1;

  // All bytes that one raw byte causes, packed from slot 0 up to last_idx.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [IDX_W-1:0]            last_idx;
    logic                        eos;
  } frame_t;

endpackage

// File: hw/rtl/zsbf_in_if.sv
interface zsbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

// File: hw/rtl/zsbf_out_if.sv
interface zsbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output last_of_run, output end_of_stream,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input end_of_stream,
                output ready);
endinterface

// File: hw/rtl/zsbf_cfg_if.sv
interface zsbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_length;

  modport source (output valid, output total_length, input ready);
  modport sink (input valid, input total_length, output ready);
endinterface

// File: hw/rtl/zlib_stored_block_framer.sv
// Channel   Direction  Payload                                  Request moves
// raw_i     in         raw_byte[7:0]                            one raw byte
// cfg_i     in         total_length[31:0]                       one length write
// zlib_o    out        out_byte[7:0], last_of_run, end_of_stream one stream byte
//
// A raw byte is taken into a holding register, framed into a group of 1 to 12
// output bytes and sent out from the frame register one byte per cycle while zlib_o
// is ready. Throughput is then one raw byte per cycle while each yields a single
// byte; a byte with headers or the trailer holds the port until its group is out.
// Reset sets the checksum and the length to 1 and clears the byte and block counts.
// Back-pressure on zlib_o stalls the frame register and then the holding register.
module zlib_stored_block_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  zsbf_in_if.sink     raw_i,
  zsbf_cfg_if.sink    cfg_i,
  zsbf_out_if.source  zlib_o
);
  import zsbf_pkg::*;

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  zsbf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .raw_i         (raw_i),
    .cfg_i         (cfg_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  zsbf_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .zlib_o        (zlib_o)
  );

endmodule

// File: hw/rtl/zsbf_core.sv
module zsbf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  zsbf_in_if.sink          raw_i,
  zsbf_cfg_if.sink         cfg_i,
  output logic             frame_valid_o,
  output zsbf_pkg::frame_t frame_o,
  input  logic             frame_ready_i
);
  import zsbf_pkg::*;

  logic        hold_valid_q;
  logic [7:0]  hold_byte_q;
  logic [31:0] total_q;
  logic [15:0] sum_low_q, sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;
  logic [31:0] seen_q, seen_d;
  logic [15:0] remain_q, remain_d;

  logic [31:0] total_eff;
  logic [31:0] left;
  logic        last;
  logic [15:0] blk_len;
  logic        blk_final;
  logic [16:0] low_sum, low_red, high_sum, high_red;
  logic [IDX_W-1:0] pos;
  logic        fire;
  frame_t      frame;

  assign cfg_i.ready  = 1'b1;
  assign raw_i.ready  = !hold_valid_q || frame_ready_i;
  assign fire         = hold_valid_q && frame_ready_i;
  assign frame_valid_o = hold_valid_q;
  assign frame_o      = frame;

  assign total_eff = (total_q == '0) ? 32'd1 : total_q;
  assign left      = (total_eff > seen_q) ? (total_eff - seen_q) : 32'd1;
  assign last      = (left <= 32'd1);
  assign blk_final = (left <= {16'd0, MAX_BLOCK});
  assign blk_len   = blk_final ? left[15:0] : MAX_BLOCK;

  assign low_sum  = {1'b0, sum_low_q} + {9'd0, hold_byte_q};
  assign low_red  = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
  assign high_sum = {1'b0, sum_high_q} + low_red;
  assign high_red = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;

  always_comb begin
    if (last) begin
      sum_low_d  = 16'd1;
      sum_high_d = '0;
      seen_d     = '0;
      remain_d   = '0;
    end else begin
      sum_low_d  = low_red[15:0];
      sum_high_d = high_red[15:0];
      seen_d     = seen_q + 32'd1;
      remain_d   = ((remain_q == '0) ? blk_len : remain_q) - 16'd1;
    end
  end

  // Pack the output bytes in stream order; pos ends on the last slot filled.
  always_comb begin
    frame = '0;
    pos   = '0;
    if (seen_q == '0) begin
      frame.data[pos]              = ZLIB_CMF;
      frame.data[pos + IDX_W'(1)]  = ZLIB_FLG;
      pos = pos + IDX_W'(2);
    end
    if (remain_q == '0) begin
      frame.data[pos]              = {7'd0, blk_final};
      frame.data[pos + IDX_W'(1)]  = blk_len[7:0];
      frame.data[pos + IDX_W'(2)]  = blk_len[15:8];
      frame.data[pos + IDX_W'(3)]  = ~blk_len[7:0];
      frame.data[pos + IDX_W'(4)]  = ~blk_len[15:8];
      pos = pos + IDX_W'(5);
    end
    frame.data[pos] = hold_byte_q;
    if (last) begin
      frame.data[pos + IDX_W'(1)] = high_red[15:8];
      frame.data[pos + IDX_W'(2)] = high_red[7:0];
      frame.data[pos + IDX_W'(3)] = low_red[15:8];
      frame.data[pos + IDX_W'(4)] = low_red[7:0];
      pos = pos + IDX_W'(4);
      frame.eos = 1'b1;
    end
    frame.last_idx = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      total_q      <= TOTAL_LEN_RESET;
      sum_low_q    <= 16'd1;
      sum_high_q   <= '0;
      seen_q       <= '0;
      remain_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        total_q <= cfg_i.total_length;
      end
      if (raw_i.valid && raw_i.ready) begin
        hold_valid_q <= 1'b1;
      end else if (fire) begin
        hold_valid_q <= 1'b0;
      end
      if (fire) begin
        sum_low_q  <= sum_low_d;
        sum_high_q <= sum_high_d;
        seen_q     <= seen_d;
        remain_q   <= remain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_i.valid && raw_i.ready) begin
      hold_byte_q <= raw_i.raw_byte;
    end
  end

endmodule

// File: hw/rtl/zsbf_serializer.sv
module zsbf_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  input  zsbf_pkg::frame_t frame_i,
  output logic             frame_ready_o,
  zsbf_out_if.source       zlib_o
);
  import zsbf_pkg::*;

  logic             busy_q;
  frame_t           frame_q;
  logic [IDX_W-1:0] idx_q;
  logic             at_last;
  logic             out_fire;

  assign at_last  = (idx_q == frame_q.last_idx);
  assign out_fire = busy_q && zlib_o.ready;

  assign zlib_o.valid         = busy_q;
  assign zlib_o.out_byte      = frame_q.data[idx_q];
  assign zlib_o.last_of_run   = at_last;
  assign zlib_o.end_of_stream = at_last && frame_q.eos;

  // A new frame may load in the same cycle the last byte of the current one leaves.
  assign frame_ready_o = !busy_q || (out_fire && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (frame_valid_i && frame_ready_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (out_fire) begin
        if (at_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid_i && frame_ready_o) begin
      frame_q <= frame_i;
    end
  end

endmodule

// File: verif/zlib_stored_block_framer_test.sv
module zlib_stored_block_framer_test;
  import zsbf_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       eos;
  } zbyte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  zsbf_in_if  raw_if ();
  zsbf_cfg_if cfg_if ();
  zsbf_out_if zlib_if ();

  zlib_stored_block_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raw_i  (raw_if),
    .cfg_i  (cfg_if),
    .zlib_o (zlib_if)
  );

  // Framer state as the block should hold it.
  logic [31:0] total_len_q;
  logic [15:0] adl_low;
  logic [15:0] adl_high;
  logic [31:0] stream_count;
  logic [15:0] block_owed;

  logic [7:0]  raw_pending [$];
  zbyte_t      zstream_due [$];
  int unsigned raw_left;
  int unsigned mismatches;
  int unsigned bytes_out;
  int unsigned src_wait;
  int unsigned sink_wait;
  int unsigned quiet;
  logic        src_idle_en;
  logic        snk_idle_en;
  logic        hold_go;
  zbyte_t      want;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic zbyte_t plain_byte(input logic [7:0] d);
    return '{data: d, run_end: 1'b0, eos: 1'b0};
  endfunction

  task automatic clear_stream();
    adl_low      = 16'd1;
    adl_high     = 16'd0;
    stream_count = '0;
    block_owed   = '0;
  endtask

  // Works out every stream byte that one raw byte causes.
  task automatic frame_raw_byte(input logic [7:0] b);
    zbyte_t      grp [$];
    logic [31:0] eff;
    logic [31:0] left;
    logic [15:0] blen;
    logic [15:0] inv;
    logic [16:0] lo;
    logic [16:0] hi;
    logic        fin;
    eff  = (total_len_q == '0) ? 32'd1 : total_len_q;
    left = (eff > stream_count) ? eff - stream_count : 32'd1;
    fin  = (left <= 32'd1);
    if (stream_count == '0) begin
      grp = {grp, plain_byte(ZLIB_CMF)};
      grp = {grp, plain_byte(ZLIB_FLG)};
    end
    // A block header goes out only when the open block is used up, even when
    // a lowered length makes this the final byte.
    if (block_owed == '0) begin
      blen = (left < {16'd0, MAX_BLOCK}) ? left[15:0] : MAX_BLOCK;
      inv  = ~blen;
      grp = {grp, plain_byte({7'd0, ({16'd0, blen} == left)})};
      grp = {grp, plain_byte(blen[7:0])};
      grp = {grp, plain_byte(blen[15:8])};
      grp = {grp, plain_byte(inv[7:0])};
      grp = {grp, plain_byte(inv[15:8])};
      block_owed = blen;
    end
    grp = {grp, plain_byte(b)};
    block_owed   = block_owed - 16'd1;
    stream_count = stream_count + 32'd1;
    lo = {1'b0, adl_low} + {9'd0, b};
    if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
    hi = {1'b0, adl_high} + lo;
    if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
    adl_low  = lo[15:0];
    adl_high = hi[15:0];
    if (fin) begin
      grp = {grp, plain_byte(hi[15:8])};
      grp = {grp, plain_byte(hi[7:0])};
      grp = {grp, plain_byte(lo[15:8])};
      grp = {grp, plain_byte(lo[7:0])};
      grp[grp.size()-1].eos = 1'b1;
      clear_stream();
    end
    grp[grp.size()-1].run_end = 1'b1;
    zstream_due = {zstream_due, grp};
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("zlib_o byte %0d: %s", bytes_out, msg);
  endtask

  task automatic queue_raw(input logic [7:0] b);
    raw_pending = {raw_pending, b};
    raw_left++;
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 7);
      if (r == 0) queue_raw(8'h00);
      else if (r == 1) queue_raw(8'hFF);
      else queue_raw(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (raw_left != 0 || zstream_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [31:0] v);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.total_length <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    total_len_q = v;
    cfg_if.valid <= 1'b0;
  endtask

  // Raw byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_if.valid    <= 1'b0;
      raw_if.raw_byte <= '0;
      src_wait = 0;
    end else begin
      if (raw_if.valid && raw_if.ready) begin
        frame_raw_byte(raw_if.raw_byte);
        raw_left--;
      end
      if (!raw_if.valid || raw_if.ready) begin
        if (src_wait != 0) begin
          src_wait--;
          raw_if.valid <= 1'b0;
        end else if (raw_pending.size() != 0) begin
          raw_if.valid    <= 1'b1;
          raw_if.raw_byte <= raw_pending.pop_front();
          src_wait = (src_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        end else begin
          raw_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output ready, with random stalls and the long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zlib_if.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (hold_go) sink_wait = HOLD_CYCLES;
      else if (sink_wait == 0 && snk_idle_en && $urandom_range(0, 7) == 0)
        sink_wait = idle_len();
      if (sink_wait != 0) begin
        sink_wait--;
        zlib_if.ready <= 1'b0;
      end else begin
        zlib_if.ready <= 1'b1;
      end
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && zlib_if.valid && zlib_if.ready) begin
      if (zstream_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h", zlib_if.out_byte));
      end else begin
        want = zstream_due.pop_front();
        if (zlib_if.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %h, want %h", zlib_if.out_byte, want.data));
        if (zlib_if.last_of_run !== want.run_end)
          report_mismatch($sformatf("last_of_run %b, want %b", zlib_if.last_of_run,
                                    want.run_end));
        if (zlib_if.end_of_stream !== want.eos)
          report_mismatch($sformatf("end_of_stream %b, want %b", zlib_if.end_of_stream,
                                    want.eos));
      end
      bytes_out++;
    end
  end

  // Ends the run when no request of any kind completes for too long.
  always @(posedge clk_i) begin
    if ((raw_if.valid && raw_if.ready) || (zlib_if.valid && zlib_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("zlib_stored_block_framer: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [31:0] eff;
    rst_ni              = 1'b0;
    raw_if.valid        = 1'b0;
    raw_if.raw_byte     = '0;
    zlib_if.ready       = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.total_length = '0;
    hold_go             = 1'b0;
    src_idle_en         = 1'b1;
    snk_idle_en         = 1'b1;
    raw_left            = 0;
    mismatches          = 0;
    bytes_out           = 0;
    quiet               = 0;
    total_len_q         = TOTAL_LEN_RESET;
    clear_stream();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset length every byte is a whole stream.
    queue_raw(8'h00);
    queue_raw(8'hFF);
    wait_drained();
    // A length of zero acts as one.
    write_len(32'd0);
    queue_raw(8'h80);
    wait_drained();
    write_len(32'd3);
    queue_raw(8'h00);
    queue_raw(8'hFF);
    queue_raw(8'h5A);
    wait_drained();
    // Length lowered below the bytes already taken: the next byte ends the stream.
    write_len(32'd10);
    queue_raw(8'h01);
    queue_raw(8'h02);
    queue_raw(8'h04);
    queue_raw(8'h08);
    wait_drained();
    write_len(32'd2);
    queue_raw(8'h10);
    wait_drained();
    // Length raised mid-stream: a second block follows the first.
    write_len(32'd3);
    queue_raw(8'h20);
    queue_raw(8'h40);
    wait_drained();
    write_len(32'd6);
    queue_raw(8'h7F);
    queue_raw(8'h80);
    queue_raw(8'hC3);
    queue_raw(8'h3C);
    wait_drained();
    // Largest length opens a full non-final block, then the stream is cut short.
    write_len(32'hFFFF_FFFF);
    queue_raw(8'hAA);
    queue_raw(8'h55);
    wait_drained();
    write_len(32'd1);
    queue_raw(8'hE7);
    wait_drained();

    // The sender keeps offering while the output is held off, so the block backs up.
    write_len(32'd120);
    src_idle_en = 1'b0;
    hold_go <= 1'b1;
    queue_random(120);
    @(posedge clk_i);
    hold_go <= 1'b0;
    wait_drained();
    random_items = 120;

    while (random_items < 420) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) n = $urandom_range(1, 12);
      else if (pick < 18) n = $urandom_range(13, 64);
      else n = $urandom_range(100, 300);
      if (n > 420 - random_items) n = 420 - random_items;
      write_len(n);
      if ($urandom_range(0, 4) != 0) begin
        queue_random(n);
        random_items += n;
      end else begin
        // Change the length partway through, then close whatever stream is open.
        k = $urandom_range(1, n);
        queue_random(k);
        wait_drained();
        write_len($urandom_range(0, k + 8));
        eff = (total_len_q == '0) ? 32'd1 : total_len_q;
        n = (eff > stream_count) ? eff - stream_count : 1;
        queue_random(n);
        random_items += k + n;
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && zstream_due.size() == 0) begin
      $display("zlib_stored_block_framer: match");
    end else begin
      $display("zlib_stored_block_framer: mismatch");
    end
    $finish;
  end

endmodule

// File: zlib_stored_block_framer.f
hw/rtl/zsbf_pkg.sv
hw/rtl/zsbf_in_if.sv
hw/rtl/zsbf_out_if.sv
hw/rtl/zsbf_cfg_if.sv
hw/rtl/zsbf_core.sv
hw/rtl/zsbf_serializer.sv
hw/rtl/zlib_stored_block_framer.sv
verif/zlib_stored_block_framer_test.sv
